>>> rtl/core/i2j_pkg.sv
// ----------------------------------------------------------------------------
// i2j_pkg
// Shared types and constants for the ISO-2022-JP byte decoder.
// ----------------------------------------------------------------------------
package i2j_pkg;

    typedef enum logic [2:0] {
        MODE_ASCII  = 3'd0,
        MODE_ROMAN  = 3'd1,
        MODE_KANJI  = 3'd2,
        MODE_KANJI2 = 3'd3,
        MODE_ESC    = 3'd4,
        MODE_ESCPAR = 3'd5,
        MODE_ESCDOL = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        KIND_UNI   = 2'd0,
        KIND_JIS   = 2'd1,
        KIND_BAD   = 2'd2,
        KIND_TRUNC = 2'd3
    } t_kind;

    // How the back end builds the result code
    typedef enum logic [1:0] {
        OP_PASS  = 2'd0,
        OP_ROMAN = 2'd1,
        OP_PAIR  = 2'd2,
        OP_ZERO  = 2'd3
    } t_op;

    typedef struct packed {
        t_kind      kind;
        t_op        op;
        logic [7:0] data;
        logic [7:0] row;
    } t_cmd;

    localparam logic       REQ_DATA  = 1'b0;
    localparam logic       REQ_FLUSH = 1'b1;

    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_YEN    = 8'hA5;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_MACRON = 8'hAF;
    localparam logic [7:0] CH_GR_LO  = 8'h21;
    localparam logic [7:0] CH_GR_HI  = 8'h7E;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_J      = 8'h4A;
    localparam logic [7:0] CH_AT     = 8'h40;

endpackage

>>> rtl/core/i2j_front.sv
// ----------------------------------------------------------------------------
// i2j_front
// Accepts bytes, tracks the escape mode and classifies each byte into a
// command for the back end.
// ----------------------------------------------------------------------------
module i2j_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_req_type,
    input  logic [7:0]    i_in_byte,
    output logic          o_emit,
    output i2j_pkg::t_cmd o_cmd
);
    import i2j_pkg::*;

    t_mode      r_mode;
    t_mode      n_mode;
    logic [7:0] r_held_row;
    logic [7:0] n_held_row;

    logic is_esc;
    logic is_high;
    logic graphic;
    logic flush;
    logic open_seq;

    assign flush    = (i_req_type == REQ_FLUSH);
    assign is_esc   = (i_in_byte == CH_ESC);
    assign is_high  = i_in_byte[7];
    assign graphic  = (i_in_byte >= CH_GR_LO) && (i_in_byte <= CH_GR_HI);
    assign open_seq = (r_mode == MODE_KANJI2) || (r_mode == MODE_ESC) ||
                      (r_mode == MODE_ESCPAR) || (r_mode == MODE_ESCDOL);

    // Next state
    always_comb begin
        n_mode     = r_mode;
        n_held_row = r_held_row;
        if (i_accept) begin
            if (flush) begin
                if (open_seq) begin
                    n_mode = MODE_ASCII;
                end
            end else begin
                unique case (r_mode)
                    MODE_ROMAN: begin
                        if (is_esc) begin
                            n_mode = MODE_ESC;
                        end else if (is_high) begin
                            n_mode = MODE_ASCII;
                        end
                    end
                    MODE_KANJI: begin
                        if (is_esc) begin
                            n_mode = MODE_ESC;
                        end else if (!graphic) begin
                            n_mode = MODE_ASCII;
                        end else begin
                            n_held_row = i_in_byte;
                            n_mode     = MODE_KANJI2;
                        end
                    end
                    MODE_KANJI2: begin
                        n_mode = graphic ? MODE_KANJI : MODE_ASCII;
                    end
                    MODE_ESC: begin
                        if (i_in_byte == CH_DOLLAR) begin
                            n_mode = MODE_ESCDOL;
                        end else if (i_in_byte == CH_LPAREN) begin
                            n_mode = MODE_ESCPAR;
                        end else begin
                            n_mode = MODE_ASCII;
                        end
                    end
                    MODE_ESCPAR: begin
                        n_mode = (i_in_byte == CH_J) ? MODE_ROMAN : MODE_ASCII;
                    end
                    MODE_ESCDOL: begin
                        if ((i_in_byte == CH_AT) || (i_in_byte == CH_B)) begin
                            n_mode = MODE_KANJI;
                        end else begin
                            n_mode = MODE_ASCII;
                        end
                    end
                    default: begin
                        // ASCII, and the unused code acts the same
                        n_mode = is_esc ? MODE_ESC : MODE_ASCII;
                    end
                endcase
            end
        end
    end

    // Outputs
    always_comb begin
        o_emit      = 1'b0;
        o_cmd.kind  = KIND_BAD;
        o_cmd.op    = OP_ZERO;
        o_cmd.data  = i_in_byte;
        o_cmd.row   = r_held_row;
        if (flush) begin
            if (open_seq) begin
                o_emit     = 1'b1;
                o_cmd.kind = KIND_TRUNC;
            end
        end else begin
            unique case (r_mode)
                MODE_ROMAN: begin
                    if (!is_esc) begin
                        o_emit = 1'b1;
                        if (!is_high) begin
                            o_cmd.kind = KIND_UNI;
                            o_cmd.op   = OP_ROMAN;
                        end
                    end
                end
                MODE_KANJI: begin
                    o_emit = !is_esc && !graphic;
                end
                MODE_KANJI2: begin
                    o_emit = 1'b1;
                    if (graphic) begin
                        o_cmd.kind = KIND_JIS;
                        o_cmd.op   = OP_PAIR;
                    end
                end
                MODE_ESC: begin
                    o_emit = (i_in_byte != CH_DOLLAR) && (i_in_byte != CH_LPAREN);
                end
                MODE_ESCPAR: begin
                    o_emit = (i_in_byte != CH_B) && (i_in_byte != CH_J);
                end
                MODE_ESCDOL: begin
                    o_emit = (i_in_byte != CH_AT) && (i_in_byte != CH_B);
                end
                default: begin
                    if (!is_esc) begin
                        o_emit = 1'b1;
                        if (!is_high) begin
                            o_cmd.kind = KIND_UNI;
                            o_cmd.op   = OP_PASS;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_ASCII;
            r_held_row <= 8'h00;
        end else begin
            r_mode     <= n_mode;
            r_held_row <= n_held_row;
        end
    end

endmodule

>>> rtl/core/i2j_queue.sv
// ----------------------------------------------------------------------------
// i2j_queue
// Short command queue that decouples the classifier from the result stage.
// ----------------------------------------------------------------------------
module i2j_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  i2j_pkg::t_cmd i_wr_data,
    output logic          o_full,
    input  logic          i_rd_en,
    output i2j_pkg::t_cmd o_rd_data,
    output logic          o_empty
);
    import i2j_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full    = (r_count == FULL_CNT);
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_wr_en && !i_rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (!i_wr_en && i_rd_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/i2j_back.sv
// ----------------------------------------------------------------------------
// i2j_back
// Builds the result code from a queued command and holds it in the output
// register until it is popped.
// ----------------------------------------------------------------------------
module i2j_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  i2j_pkg::t_cmd i_q_cmd,
    output logic          o_q_rd,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [1:0]    o_out_kind,
    output logic [15:0]   o_out_code
);
    import i2j_pkg::*;

    logic        r_valid;
    logic [1:0]  r_kind;
    logic [15:0] r_code;
    logic [15:0] n_code;
    logic [7:0]  roman;

    // Refill the output register when it is free or being drained
    assign o_q_rd = !i_q_empty && (!r_valid || i_pop);

    always_comb begin
        priority if (i_q_cmd.data == CH_BSLASH) begin
            roman = CH_YEN;
        end else if (i_q_cmd.data == CH_TILDE) begin
            roman = CH_MACRON;
        end else begin
            roman = i_q_cmd.data;
        end
    end

    always_comb begin
        unique case (i_q_cmd.op)
            OP_PASS:  n_code = {8'h00, i_q_cmd.data};
            OP_ROMAN: n_code = {8'h00, roman};
            OP_PAIR:  n_code = {i_q_cmd.row, i_q_cmd.data};
            default:  n_code = 16'h0000;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_rd) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_kind <= i_q_cmd.kind;
            r_code <= n_code;
        end
    end

    assign o_empty    = !r_valid;
    assign o_out_kind = r_kind;
    assign o_out_code = r_code;

endmodule

>>> rtl/core/iso2022jp_byte_decoder_top.sv
// ----------------------------------------------------------------------------
// iso2022jp_byte_decoder_top
// ISO-2022-JP byte decoder with queue-style input and result ports.
// ----------------------------------------------------------------------------
// Takes one byte or flush marker per clock while full is low, and gives at
// most one result per item. The classifier decodes the byte against the
// escape mode and writes a command into a queue of QUEUE_DEPTH entries when
// the item is accepted, and the result stage builds the code into the output
// register once that register is empty or being popped.
// Sustained rate is one item per cycle; full rises only when the queue fills
// because results are not being popped. Double-byte results carry the raw
// row*256+column JIS X 0208 code for lookup outside the block.
module iso2022jp_byte_decoder_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_req_type,
    input  logic [7:0]  i_in_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_out_kind,
    output logic [15:0] o_out_code
);
    import i2j_pkg::*;

    logic accept;
    logic emit;
    logic q_full;
    logic q_empty;
    logic q_rd;
    t_cmd cmd;
    t_cmd q_cmd;

    assign full   = q_full;
    assign accept = push && !q_full;

    i2j_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req_type (i_req_type),
        .i_in_byte  (i_in_byte),
        .o_emit     (emit),
        .o_cmd      (cmd)
    );

    i2j_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (accept && emit),
        .i_wr_data (cmd),
        .o_full    (q_full),
        .i_rd_en   (q_rd),
        .o_rd_data (q_cmd),
        .o_empty   (q_empty)
    );

    i2j_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_cmd    (q_cmd),
        .o_q_rd     (q_rd),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_kind (o_out_kind),
        .o_out_code (o_out_code)
    );

endmodule

>>> bench/iso2022jp_byte_decoder_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iso2022jp_byte_decoder_top_tb
// Self-checking bench for the ISO-2022-JP byte decoder.
// ----------------------------------------------------------------------------
// A clocked driver pushes bytes and flush markers from a prepared stream in
// random bursts. A clocked monitor pops results on a changing stall pattern.
// Every accepted byte runs through a local decoder model, which queues the
// result it should produce. Each popped result is checked against the oldest
// queued one. The stream opens with hand-picked cases: escape switches,
// JIS-Roman remaps, double-byte pairs, invalid bytes and truncating flushes.
// It then runs mostly well-formed escape runs with random content, plus noise.
// Once, the monitor stops popping for a long stretch so that full comes up.
// ----------------------------------------------------------------------------
module iso2022jp_byte_decoder_top_tb;

    import i2j_pkg::*;

    localparam int N_ITEMS   = 1450;
    localparam int HOLD_CYC  = 300;
    localparam int DRAIN_CYC = 10;

    typedef struct {
        logic       req;
        logic [7:0] data;
    } t_in_item;

    typedef struct {
        t_kind       kind;
        logic [15:0] code;
    } t_decoded;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        push       = 1'b0;
    logic        i_req_type = REQ_DATA;
    logic [7:0]  i_in_byte  = 8'h00;
    logic        pop        = 1'b0;
    logic        hold_off   = 1'b0;
    logic        full;
    logic        empty;
    logic [1:0]  o_out_kind;
    logic [15:0] o_out_code;

    t_in_item input_stream[$];
    t_decoded expected_results[$];

    // decoder model state
    t_mode      dec_mode = MODE_ASCII;
    logic [7:0] dec_row  = 8'h00;

    int n_items_total = 0;
    int n_sent        = 0;
    int n_checked     = 0;
    int n_fail        = 0;
    int n_full_cycles = 0;
    int kind_count[4] = '{0, 0, 0, 0};

    int burst_left = 0;
    int gap_left   = 0;
    int pop_style  = 0;
    int style_left = 0;
    logic [7:0] pop_mask = 8'hFF;

    iso2022jp_byte_decoder_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_req_type (i_req_type),
        .i_in_byte  (i_in_byte),
        .empty      (empty),
        .pop        (pop),
        .o_out_kind (o_out_kind),
        .o_out_code (o_out_code)
    );

    always #4 i_clk = ~i_clk;

    function automatic void emit_decoded(t_kind kind, logic [15:0] code);
        t_decoded r;
        r.kind = kind;
        r.code = code;
        expected_results.push_back(r);
    endfunction

    function automatic void reject_byte();
        dec_mode = MODE_ASCII;
        emit_decoded(KIND_BAD, 16'h0000);
    endfunction

    function automatic void decode_step(logic req, logic [7:0] b);
        logic graphic;
        graphic = (b >= CH_GR_LO) && (b <= CH_GR_HI);
        if (req == REQ_FLUSH) begin
            if (dec_mode inside {MODE_KANJI2, MODE_ESC, MODE_ESCPAR, MODE_ESCDOL}) begin
                dec_mode = MODE_ASCII;
                emit_decoded(KIND_TRUNC, 16'h0000);
            end
        end else begin
            case (dec_mode)
                MODE_ROMAN: begin
                    if (b == CH_ESC) dec_mode = MODE_ESC;
                    else if (b[7]) reject_byte();
                    else if (b == CH_BSLASH) emit_decoded(KIND_UNI, {8'h00, CH_YEN});
                    else if (b == CH_TILDE) emit_decoded(KIND_UNI, {8'h00, CH_MACRON});
                    else emit_decoded(KIND_UNI, {8'h00, b});
                end
                MODE_KANJI: begin
                    if (b == CH_ESC) begin
                        dec_mode = MODE_ESC;
                    end else if (!graphic) begin
                        reject_byte();
                    end else begin
                        dec_row  = b;
                        dec_mode = MODE_KANJI2;
                    end
                end
                MODE_KANJI2: begin
                    if (!graphic) begin
                        reject_byte();
                    end else begin
                        dec_mode = MODE_KANJI;
                        emit_decoded(KIND_JIS, {dec_row, b});
                    end
                end
                MODE_ESC: begin
                    if (b == CH_DOLLAR) dec_mode = MODE_ESCDOL;
                    else if (b == CH_LPAREN) dec_mode = MODE_ESCPAR;
                    else reject_byte();
                end
                MODE_ESCPAR: begin
                    if (b == CH_B) dec_mode = MODE_ASCII;
                    else if (b == CH_J) dec_mode = MODE_ROMAN;
                    else reject_byte();
                end
                MODE_ESCDOL: begin
                    if (b == CH_AT || b == CH_B) dec_mode = MODE_KANJI;
                    else reject_byte();
                end
                default: begin
                    if (b == CH_ESC) dec_mode = MODE_ESC;
                    else if (b[7]) reject_byte();
                    else emit_decoded(KIND_UNI, {8'h00, b});
                end
            endcase
        end
    endfunction

    function automatic void queue_byte(logic [7:0] b);
        t_in_item it;
        it.req  = REQ_DATA;
        it.data = b;
        input_stream.push_back(it);
    endfunction

    function automatic void queue_flush();
        t_in_item it;
        it.req  = REQ_FLUSH;
        it.data = 8'($urandom_range(0, 255));
        input_stream.push_back(it);
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] graphic_byte();
        return 8'($urandom_range(CH_GR_LO, CH_GR_HI));
    endfunction

    // Sender: random bursts and gaps, hold the item while full is up
    always @(posedge i_clk) begin
        t_in_item it;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                decode_step(i_req_type, i_in_byte);
                n_sent++;
            end
            if (push && full) begin
                n_full_cycles++;
            end else if (gap_left > 0 || input_stream.size() == 0) begin
                if (gap_left > 0) gap_left--;
                push <= 1'b0;
            end else begin
                it = input_stream.pop_front();
                push       <= 1'b1;
                i_req_type <= it.req;
                i_in_byte  <= it.data;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // Receiver: check each popped transaction, then pick the next pop
    always @(posedge i_clk) begin
        t_decoded want;
        logic     want_pop;
        if (i_rst_n && pop && !empty) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: out_kind %0d out_code %h", o_out_kind, o_out_code);
                n_fail++;
            end else begin
                want = expected_results.pop_front();
                if (o_out_kind !== want.kind) begin
                    $error("out_kind: expected %0d, actual %0d", want.kind, o_out_kind);
                    n_fail++;
                end
                if (o_out_code !== want.code) begin
                    $error("out_code: expected %h, actual %h", want.code, o_out_code);
                    n_fail++;
                end
                kind_count[want.kind]++;
                n_checked++;
            end
        end
        if (style_left == 0) begin
            pop_style  = $urandom_range(0, 3);
            style_left = $urandom_range(20, 150);
            pop_mask   = 8'($urandom_range(1, 255));
        end else begin
            style_left--;
        end
        case (pop_style)
            0: want_pop = 1'b1;
            1: want_pop = 1'($urandom_range(0, 1));
            2: want_pop = ($urandom_range(0, 3) == 0);
            default: begin
                pop_mask = {pop_mask[6:0], pop_mask[7]};
                want_pop = pop_mask[0];
            end
        endcase
        pop <= i_rst_n && !hold_off && want_pop;
    end

    // Long receiver hold-off while the sender keeps offering
    initial begin
        wait (n_sent >= 500);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYC) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("timeout: %0d of %0d items sent, %0d results pending",
                 n_sent, n_items_total, expected_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int sel;
        int len;
        logic [7:0] b;

        // ASCII extremes, an invalid high byte, flush with nothing pending
        queue_byte(8'h41); queue_byte(8'h00); queue_byte(8'hFF); queue_byte(8'h7F);
        queue_flush();
        // JIS-Roman remaps, flush with nothing pending, invalid high byte
        queue_byte(CH_ESC); queue_byte(CH_LPAREN); queue_byte(CH_J);
        queue_byte(CH_BSLASH); queue_byte(CH_TILDE); queue_flush(); queue_byte(8'h80);
        // double-byte pair at the graphic bounds, then ESC in the middle of a pair
        queue_byte(CH_ESC); queue_byte(CH_DOLLAR); queue_byte(CH_B);
        queue_flush();
        queue_byte(CH_GR_LO); queue_byte(CH_GR_HI);
        queue_byte(CH_GR_HI); queue_byte(CH_ESC);
        // non-graphic byte where a row is expected
        queue_byte(CH_ESC); queue_byte(CH_DOLLAR); queue_byte(CH_AT); queue_byte(8'h20);
        // bad byte after ESC (, then truncated escapes
        queue_byte(CH_ESC); queue_byte(CH_LPAREN); queue_byte(8'h41);
        queue_byte(CH_ESC); queue_flush();
        queue_byte(CH_ESC); queue_byte(CH_DOLLAR); queue_flush();

        while (input_stream.size() < N_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                queue_byte(CH_ESC); queue_byte(CH_DOLLAR);
                queue_byte($urandom_range(0, 1) ? CH_B : CH_AT);
                len = $urandom_range(1, 8);
                repeat (len) begin
                    queue_byte(graphic_byte());
                    queue_byte(graphic_byte());
                end
                if ($urandom_range(0, 4) == 0) begin
                    queue_byte(graphic_byte());
                    queue_flush();
                end
            end else if (sel < 65) begin
                queue_byte(CH_ESC); queue_byte(CH_LPAREN);
                queue_byte($urandom_range(0, 1) ? CH_B : CH_J);
                len = $urandom_range(1, 10);
                repeat (len) begin
                    if ($urandom_range(0, 3) == 0) begin
                        b = $urandom_range(0, 1) ? CH_BSLASH : CH_TILDE;
                    end else begin
                        b = 8'($urandom_range(0, 127));
                    end
                    if (b == CH_ESC) b = CH_BSLASH;
                    queue_byte(b);
                end
            end else if (sel < 75) begin
                queue_flush();
            end else if (sel < 88) begin
                len = $urandom_range(1, 6);
                repeat (len) queue_byte(any_byte());
            end else begin
                // broken escape sequences
                queue_byte(CH_ESC);
                case ($urandom_range(0, 4))
                    0: queue_byte(any_byte());
                    1: begin queue_byte(CH_LPAREN); queue_byte(any_byte()); end
                    2: begin queue_byte(CH_DOLLAR); queue_byte(any_byte()); end
                    3: queue_flush();
                    default: begin
                        queue_byte($urandom_range(0, 1) ? CH_DOLLAR : CH_LPAREN);
                        queue_flush();
                    end
                endcase
            end
        end
        n_items_total = input_stream.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (n_sent == n_items_total);
        wait (expected_results.size() == 0);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            n_fail++;
        end
        $display("run covered %0d items and %0d results: %0d chars, %0d JIS codes,",
                 n_items_total, n_checked, kind_count[KIND_UNI], kind_count[KIND_JIS]);
        $display("  %0d invalid bytes, %0d truncations; input held by full for %0d cycles",
                 kind_count[KIND_BAD], kind_count[KIND_TRUNC], n_full_cycles);
        if (n_fail == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
